// ===== hw/rtl/spi_ethernet_rx_deframer_macros.svh =====
// Assertion macros for the receive deframer.
// Used by files that assert; expects clk and arst_n in scope.
`ifndef SPI_ETHERNET_RX_DEFRAMER_MACROS_SVH
`define SPI_ETHERNET_RX_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPERX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SPERX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sperx_pkg.sv =====
// Shared types and constants for the SPI ethernet receive deframer.
// No dependencies.
package sperx_pkg;

	// Receive buffer size; bursts longer than this are clamped
	localparam int MAX_BUFFER_BYTES = 4096;
	localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
	localparam int LEN_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int SUM_W = 17;
	localparam int CFG_W = 13;

	localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = CFG_W'(1522);
	localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;

	// Byte offsets within a burst
	localparam logic [POS_W-1:0] POS_PRE_FIRST = POS_W'(4);
	localparam logic [POS_W-1:0] POS_PRE_LAST  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(8);
	localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(9);
	localparam logic [SUM_W-1:0] HEADER_BYTES  = SUM_W'(12);
	localparam logic [SUM_W-1:0] TRAILER_BYTES = SUM_W'(2);
	localparam logic [LEN_W-1:0] MIN_BURST     = LEN_W'(14);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_PREAMBLE = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_OVERRUN  = 3'd4
	} frame_status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] buffer_bytes;
	} in_beat_t;

	typedef struct packed {
		logic          is_status;
		logic [7:0]    payload_byte;
		logic          last_payload;
		frame_status_t frame_status;
		logic [15:0]   frame_length;
	} out_beat_t;

	// Result handed from the decoder to the output register
	typedef struct packed {
		logic      valid;
		out_beat_t beat;
	} dec_res_t;

endpackage

// ===== hw/rtl/spi_ethernet_rx_deframer.sv =====
// Top level of the SPI ethernet receive deframer: input register, decoder, output register.
// Depends on sperx_pkg, sperx_decode, sperx_out_buf and the macros header.
//
//   port group | dir | beat
//   in_*       | in  | one burst byte plus burst count
//   out_*      | out | payload byte or end-of-burst status
//   cfg_*      | in  | max_frame_len write, no handshake
//
// One byte per cycle sustained unless a result meets a full output; registered in and out.
// Rate is set by the byte position counter and header compares, one pass per byte.
// Reset clears all control state and loads max_frame_len with 1522.
// A stalled output holds only bytes that produce a result; other bytes keep flowing.
`include "spi_ethernet_rx_deframer_macros.svh"

module spi_ethernet_rx_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sperx_pkg::in_beat_t         in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sperx_pkg::out_beat_t        out_data,
	input  logic                        cfg_we,
	input  logic [sperx_pkg::CFG_W-1:0] cfg_wdata
);
	import sperx_pkg::*;

	logic     valid_s1;
	in_beat_t item_s1;
	dec_res_t res;
	logic     space;
	logic     adv;

	// Byte in stage 1 moves on unless its result finds the output full
	assign adv      = valid_s1 && (!res.valid || space);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sperx_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (valid_s1),
		.adv        (adv),
		.item       (item_s1),
		.res        (res)
	);

	sperx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.load      (adv),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Checks
	`SPERX_ASSERT_NOW(a_payload_clean, out_valid && !out_data.is_status, out_data.frame_status == ST_OK && out_data.frame_length == 16'd0, "payload beat carries status fields")
	`SPERX_ASSERT_NOW(a_short_no_len, out_valid && out_data.is_status && out_data.frame_status == ST_SHORT, out_data.frame_length == 16'd0 && !out_data.last_payload, "short burst status carries a length")
	`SPERX_ASSERT_NOW(a_stall_cause, valid_s1 && !in_ready, out_valid && !out_ready, "input stalled without a blocked output")
	`SPERX_ASSERT_NEXT(a_drain, out_valid && out_ready && !valid_s1, !out_valid, "result beat appeared with no byte in flight")

endmodule

// ===== hw/rtl/sperx_decode.sv =====
// Burst decoder: byte position, header parse, error checks, result build.
// Depends on sperx_pkg.
module sperx_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sperx_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                          item_valid,
	input  logic                          adv,
	input  sperx_pkg::in_beat_t           item,
	output sperx_pkg::dec_res_t           res
);
	import sperx_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] blen_q;
	logic [15:0]      dlen_q;
	frame_status_t    err_q;
	logic [CFG_W-1:0] max_len_q;

	logic [LEN_W-1:0] blen_new;
	logic [LEN_W-1:0] blen_cur;
	logic [15:0]      dlen_nxt;
	frame_status_t    err_nxt;
	logic             pay_hit;
	logic             pay_last;
	logic             last_byte;

	// Clamp the burst count taken on the first byte
	always_comb begin
		if (item.buffer_bytes == 16'd0) begin
			blen_new = LEN_W'(1);
		end else if (item.buffer_bytes > 16'(MAX_BUFFER_BYTES)) begin
			blen_new = LEN_W'(MAX_BUFFER_BYTES);
		end else begin
			blen_new = LEN_W'(item.buffer_bytes);
		end
	end

	// Header parse and checks for the current byte
	always_comb begin
		logic          first;
		logic [15:0]   dlen_cur;
		frame_status_t err_cur;
		logic [15:0]   dlen_hi;
		logic [SUM_W-1:0] pos_w;
		logic [SUM_W-1:0] hdr_end;

		first    = (pos_q == '0);
		blen_cur = first ? blen_new : blen_q;
		dlen_cur = first ? 16'd0 : dlen_q;
		err_cur  = first ? ((blen_new < MIN_BURST) ? ST_SHORT : ST_OK) : err_q;
		dlen_hi  = {item.data_byte, dlen_cur[7:0]};
		pos_w    = SUM_W'(pos_q);
		hdr_end  = HEADER_BYTES + SUM_W'(dlen_cur);

		dlen_nxt = dlen_cur;
		err_nxt  = err_cur;
		pay_hit  = 1'b0;
		pay_last = 1'b0;

		if (pos_q inside {[POS_PRE_FIRST:POS_PRE_LAST]}) begin
			if (err_cur == ST_OK && item.data_byte != PREAMBLE_BYTE) begin
				err_nxt = ST_PREAMBLE;
			end
		end else if (pos_q == POS_LEN_LO) begin
			dlen_nxt = {8'h00, item.data_byte};
		end else if (pos_q == POS_LEN_HI) begin
			dlen_nxt = dlen_hi;
			if (err_cur == ST_OK) begin
				if (dlen_hi > 16'(max_len_q)) begin
					err_nxt = ST_TOO_LONG;
				end else if (HEADER_BYTES + SUM_W'(dlen_hi) + TRAILER_BYTES
						> SUM_W'(blen_cur)) begin
					err_nxt = ST_OVERRUN;
				end
			end
		end else if (pos_w >= HEADER_BYTES && err_cur == ST_OK && pos_w < hdr_end) begin
			pay_hit  = 1'b1;
			pay_last = (pos_w == hdr_end - SUM_W'(1));
		end

		last_byte = (SUM_W'(pos_q) + SUM_W'(1)) >= SUM_W'(blen_cur);
	end

	// Result: status wins over payload on the final burst byte
	always_comb begin
		res.valid             = item_valid && (last_byte || pay_hit);
		res.beat.is_status    = last_byte;
		res.beat.payload_byte = last_byte ? 8'h00 : item.data_byte;
		res.beat.last_payload = last_byte ? 1'b0 : pay_last;
		res.beat.frame_status = last_byte ? err_nxt : ST_OK;
		res.beat.frame_length = (last_byte && err_nxt != ST_SHORT) ? dlen_nxt : 16'd0;
	end

	// Burst state and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			blen_q    <= '0;
			dlen_q    <= '0;
			err_q     <= ST_OK;
			max_len_q <= MAX_FRAME_LEN_RST;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (adv) begin
				pos_q  <= last_byte ? '0 : pos_q + POS_W'(1);
				blen_q <= blen_cur;
				dlen_q <= dlen_nxt;
				err_q  <= err_nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/sperx_out_buf.sv =====
// Output result register with valid/ready handshake.
// Depends on sperx_pkg.
module sperx_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sperx_pkg::dec_res_t  res,
	input  logic                 load,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sperx_pkg::out_beat_t out_data
);
	import sperx_pkg::*;

	logic      valid_q;
	out_beat_t beat_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = beat_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && res.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			beat_q <= res.beat;
		end
	end

endmodule
